FILE: hw/rtl/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHK_IMPLY(label, clk, rst, ante, cons)
`define CHK_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/hmac_pkg.sv
// ----------------------------------------------------------------------------
// hmac_pkg
// Types, round constants and SHA-256 helper functions.
// ----------------------------------------------------------------------------
package hmac_pkg;

  localparam int unsigned NUM_KEY_WORDS = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY,
    ST_ABSORB,
    ST_PAD,
    ST_LEN,
    ST_COPY,
    ST_OKEY,
    ST_OUTER,
    ST_SEND
  } ctl_state_t;

  // Block source selector for the compression unit
  typedef enum logic [2:0] {
    SRC_IPAD,
    SRC_OPAD,
    SRC_MEM,
    SRC_OUTER
  } blk_src_t;

  typedef struct packed {
    logic     start;
    logic     init_iv;
    blk_src_t src;
  } cmp_ctl_t;

  localparam logic [31:0] IPAD_WORD = 32'h36363636;
  localparam logic [31:0] OPAD_WORD = 32'h5c5c5c5c;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    ror32 = (v >> n) | (v << (32 - n));
  endfunction

endpackage

FILE: hw/rtl/hmac_compress.sv
// ----------------------------------------------------------------------------
// hmac_compress
// SHA-256 compression, one round per cycle, schedule in a 16-word window.
// The block words come in one per cycle over the first 16 rounds.
// ----------------------------------------------------------------------------
module hmac_compress (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,    // begin a block; chain_in is the value
  input  logic [8*32-1:0]   chain_in,
  input  logic [31:0]       blk_word, // word for round number round_idx
  output logic [5:0]        round_idx,
  output logic              busy,
  output logic              done,     // one pulse, chain_out valid in that cycle
  output logic [8*32-1:0]   chain_out
);
  import hmac_pkg::*;

  logic [31:0] w [16];
  logic [31:0] r [8];
  logic [31:0] hv [8];
  logic [5:0]  cnt;
  logic        run;
  logic        fin;
  logic [31:0] wt, s0, s1, e, a, t1, t2;

  // Schedule word for this round
  always_comb begin
    s0 = ror32(w[1], 7) ^ ror32(w[1], 18) ^ (w[1] >> 3);
    s1 = ror32(w[14], 17) ^ ror32(w[14], 19) ^ (w[14] >> 10);
    wt = (cnt < 6'd16) ? blk_word : (w[0] + s0 + w[9] + s1);
    e  = r[4];
    a  = r[0];
    t1 = r[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
         + ((e & r[5]) ^ (~e & r[6])) + ROUND_K[cnt] + wt;
    t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
         + ((a & r[1]) ^ (a & r[2]) ^ (r[1] & r[2]));
  end

  // Advance rounds
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= 1'b0;
      if (start && !run) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  // Working registers and input chaining value
  always_ff @(posedge clk) begin
    if (start && !run) begin
      for (int i = 0; i < 8; i++) begin
        r[i]  <= chain_in[(7-i)*32 +: 32];
        hv[i] <= chain_in[(7-i)*32 +: 32];
      end
    end else if (run) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wt;
      r[7] <= r[6]; r[6] <= r[5]; r[5] <= r[4]; r[4] <= r[3] + t1;
      r[3] <= r[2]; r[2] <= r[1]; r[1] <= r[0]; r[0] <= t1 + t2;
    end
  end

  // Feed-forward sum, taken while done is high
  always_comb begin
    for (int i = 0; i < 8; i++) chain_out[(7-i)*32 +: 32] = hv[i] + r[i];
  end

  assign round_idx = cnt;
  assign busy      = run | fin;
  assign done      = fin;

  `include "assert_macros.svh"
  `CHK_NEXT(a_fin_pulse, clk, rst, fin, !fin)
  `CHK_IMPLY(a_no_start_busy, clk, rst, fin, !run)
  `CHK_NEXT(a_last_round, clk, rst, run && cnt == 6'd63, fin && !run)

endmodule

FILE: hw/rtl/hmac_sha256_engine.sv
// ----------------------------------------------------------------------------
// hmac_sha256_engine
// HMAC-SHA256 over a byte stream with a 64-byte key held in registers.
// ----------------------------------------------------------------------------
// Channel  | Dir | Payload
// s_axis   | in  | tdata[7:0] msg_byte, tuser[0] has_byte, tlast last
// m_axis   | out | tdata[63:0] mac_word, tuser[1:0] word_index, tlast last_word
// cfg      | in  | cfg_index[3:0] register, cfg_data[63:0] value
//
// A byte item does not hold the input unless it completes a block; a full
// block then holds the input while the round unit runs (one round per cycle).
// The first item of a message adds one key-block compression; a last item
// adds the pad state, one or two padding blocks, the copy state and two
// outer blocks, then the four MAC words.
// Reset is synchronous; the block buffer needs no clearing.
// A stalled output holds the result register; no input is taken meanwhile.
// ----------------------------------------------------------------------------
module hmac_sha256_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] mac_word
  output logic [1:0]  m_axis_tuser,   // [1:0] word_index
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import hmac_pkg::*;

  logic [63:0]  key [NUM_KEY_WORDS];
  ctl_state_t   state, state_next;
  logic         in_msg;         // a message is running
  logic [63:0]  bit_count;
  logic [5:0]   fill;           // bytes in the block buffer
  logic [31:0]  cur_word;       // word being assembled
  logic         last_pend;
  logic         pad_two;        // padding needs a second block
  logic         pad_second;
  logic [255:0] chain;
  logic [255:0] inner;
  logic [1:0]   out_cnt;

  // Block buffer: 16 words, one write and one read port
  logic [31:0]  blk_mem [16];
  logic         mem_we;
  logic [3:0]   mem_waddr;
  logic [31:0]  mem_wdata;
  logic [31:0]  mem_rdata;
  logic [3:0]   mem_raddr;
  logic [3:0]   rd_q;
  logic [31:0]  pad_word;
  logic [3:0]   pw;

  logic         cmp_start, cmp_busy, cmp_done;
  logic         started;
  logic [5:0]   round_idx;
  logic [255:0] cmp_out;
  logic [255:0] cmp_in;
  logic [31:0]  blk_word;
  cmp_ctl_t     ctl;
  logic         in_fire;
  logic [63:0]  len;
  logic [63:0]  kw;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KEY_WORDS; i++) key[i] <= '0;
    end else if (cfg_valid && cfg_index < 4'd8) begin
      key[cfg_index[2:0]] <= cfg_data;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign len = bit_count + 64'd512;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && !in_msg) state_next = ST_KEY;
        else if (in_fire && s_axis_tuser && fill == 6'd63) state_next = ST_ABSORB;
        else if (in_fire && s_axis_tlast) state_next = ST_PAD;
      end
      ST_KEY:    if (cmp_done) state_next = last_pend ? ST_PAD : ST_IDLE;
      ST_ABSORB: if (cmp_done) state_next = last_pend ? ST_PAD : ST_IDLE;
      ST_PAD:    state_next = ST_LEN;
      ST_LEN:    if (cmp_done) state_next = (pad_two && !pad_second) ? ST_LEN : ST_COPY;
      ST_COPY:   state_next = ST_OKEY;
      ST_OKEY:   if (cmp_done) state_next = ST_OUTER;
      ST_OUTER:  if (cmp_done) state_next = ST_SEND;
      ST_SEND:   if (m_axis_tready && out_cnt == 2'd3) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Compression control per state
  always_comb begin
    ctl = '{start: 1'b0, init_iv: 1'b0, src: SRC_MEM};
    case (state)
      ST_KEY:   ctl = '{start: !cmp_busy, init_iv: 1'b1, src: SRC_IPAD};
      ST_ABSORB:ctl = '{start: !cmp_busy, init_iv: 1'b0, src: SRC_MEM};
      ST_LEN:   ctl = '{start: !cmp_busy, init_iv: 1'b0, src: SRC_MEM};
      ST_OKEY:  ctl = '{start: !cmp_busy, init_iv: 1'b1, src: SRC_OPAD};
      ST_OUTER: ctl = '{start: !cmp_busy, init_iv: 1'b0, src: SRC_OUTER};
      default:  ctl = '{start: 1'b0, init_iv: 1'b0, src: SRC_MEM};
    endcase
  end

  // Start only once per block: busy covers the round run and done pulse
  assign cmp_start = ctl.start && !started;
  always_comb begin
    for (int i = 0; i < 8; i++) cmp_in[(7-i)*32 +: 32] = START_IV[i];
    if (!ctl.init_iv) cmp_in = chain;
  end

  // Block word for the current round
  assign mem_raddr = (cmp_start || !cmp_busy) ? 4'd0 : 4'(round_idx + 6'd1);
  always_comb begin
    kw = key[round_idx[3:1]];
    case (ctl.src)
      SRC_IPAD:  blk_word = (round_idx[0] ? kw[31:0] : kw[63:32]) ^ IPAD_WORD;
      SRC_OPAD:  blk_word = (round_idx[0] ? kw[31:0] : kw[63:32]) ^ OPAD_WORD;
      SRC_OUTER: begin
        if (round_idx < 6'd8) blk_word = inner[(7 - round_idx[2:0])*32 +: 32];
        else if (round_idx == 6'd8) blk_word = 32'h80000000;
        else if (round_idx == 6'd15) blk_word = 32'd768;
        else blk_word = '0;
      end
      default:   blk_word = pad_word;
    endcase
  end

  hmac_compress u_cmp (
    .clk      (clk),
    .rst      (rst),
    .start    (cmp_start),
    .chain_in (cmp_in),
    .blk_word (blk_word),
    .round_idx(round_idx),
    .busy     (cmp_busy),
    .done     (cmp_done),
    .chain_out(cmp_out)
  );

  // Memory write: byte words; the first byte of a message opens word 0
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill[5:2];
    mem_wdata = cur_word;
    if (state == ST_IDLE && in_fire && s_axis_tuser) begin
      mem_we = 1'b1;
      if (!in_msg) begin
        mem_waddr = 4'd0;
        mem_wdata = {s_axis_tdata, 24'd0};
      end else begin
        mem_wdata = (fill[1:0] == 2'd0) ? {s_axis_tdata, 24'd0}
                  : (cur_word | ({24'd0, s_axis_tdata} << (5'd24 - {fill[1:0], 3'd0})));
      end
    end
  end

  // Read port: block buffer with padding overlay
  always_ff @(posedge clk) begin
    if (mem_we) blk_mem[mem_waddr] <= mem_wdata;
    rd_q <= mem_raddr;
  end
  always_ff @(posedge clk) begin
    mem_rdata <= blk_mem[mem_raddr];
  end
  // Padding view of the buffer
  always_comb begin
    pw = fill[5:2];
    pad_word = mem_rdata;
    if (state == ST_LEN) begin
      if (pad_second) begin
        pad_word = '0;
      end else if (rd_q == pw) begin
        pad_word = (fill[1:0] == 2'd0) ? 32'h80000000
                 : ((cur_word & ~(32'hffffffff >> {fill[1:0], 3'd0}))
                    | (32'h80000000 >> {fill[1:0], 3'd0}));
      end else if (rd_q > pw) begin
        pad_word = '0;
      end
      if (!pad_two || pad_second) begin
        if (rd_q == 4'd14) pad_word = len[63:32];
        if (rd_q == 4'd15) pad_word = len[31:0];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; in_msg <= 1'b0; bit_count <= '0; fill <= '0;
      last_pend <= 1'b0; pad_second <= 1'b0; out_cnt <= '0; started <= 1'b0;
      pad_two <= 1'b0;
    end else begin
      state <= state_next;
      if (cmp_start) started <= 1'b1;
      if (cmp_done) started <= 1'b0;
      if (in_fire) begin
        in_msg <= !s_axis_tlast;
        last_pend <= s_axis_tlast;
        if (!in_msg) begin
          bit_count <= s_axis_tuser ? 64'd8 : 64'd0;
          fill <= s_axis_tuser ? 6'd1 : 6'd0;
        end else if (s_axis_tuser) begin
          bit_count <= bit_count + 64'd8;
          fill <= fill + 6'd1;
        end
      end
      if (state == ST_PAD) pad_two <= (fill >= 6'd56);
      if (state == ST_LEN && cmp_done) pad_second <= pad_two && !pad_second;
      if (state == ST_COPY) pad_second <= 1'b0;
      if (state == ST_SEND && m_axis_tready) out_cnt <= out_cnt + 2'd1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (mem_we) cur_word <= mem_wdata;
    if (cmp_done) chain <= cmp_out;
    if (state == ST_COPY) inner <= chain;
  end

  assign m_axis_tvalid = (state == ST_SEND);
  assign m_axis_tdata  = chain[(3 - out_cnt)*64 +: 64];
  assign m_axis_tuser  = out_cnt;
  assign m_axis_tlast  = (out_cnt == 2'd3);

  `include "assert_macros.svh"
  `CHK_IMPLY(a_no_in_busy, clk, rst, cmp_busy, !s_axis_tready)
  `CHK_IMPLY(a_send_idle, clk, rst, m_axis_tvalid, !cmp_busy)
  `CHK_NEXT(a_hold_out, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(out_cnt))

endmodule
